[rtl/core/darr_pkg.sv]
// shared types and constants of the dram access round-robin arbiter
// no dependencies; used by the interfaces, darr_qbook, the top level and darr_chk
package darr_pkg;

	localparam int MAX_STREAMS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int STREAM_W = 3;
	localparam int SIZE_W   = 20;
	localparam int KIND_W   = 2;
	localparam int TAG_W    = 16;
	localparam int ACT_W    = 4;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 32;

	typedef enum logic {
		REQ_NEW  = 1'b0,
		REQ_DONE = 1'b1
	} req_type_t;

	typedef enum logic {
		REG_MODE    = 1'b0,
		REG_STREAMS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [STREAM_W-1:0] stream;
		logic [SIZE_W-1:0]   size;
		logic [KIND_W-1:0]   kind;
		logic [TAG_W-1:0]    tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic push;
		logic pop;
	} book_op_t;

endpackage

[rtl/core/darr_if.sv]
// request and issue channels of the arbiter, valid/ready with payload
// depends on darr_pkg for field widths
interface darr_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [darr_pkg::STREAM_W-1:0] req_stream;
	logic [darr_pkg::SIZE_W-1:0]   size_bytes;
	logic [darr_pkg::KIND_W-1:0]   access_kind;
	logic [darr_pkg::TAG_W-1:0]    request_tag;

	modport source (output valid, req_type, req_stream, size_bytes, access_kind, request_tag,
		input ready);
	modport sink (input valid, req_type, req_stream, size_bytes, access_kind, request_tag,
		output ready);
endinterface

interface darr_iss_if;
	logic                          valid;
	logic                          ready;
	logic                          issue_valid;
	logic [darr_pkg::STREAM_W-1:0] issue_stream;
	logic [darr_pkg::SIZE_W-1:0]   issue_size;
	logic [darr_pkg::KIND_W-1:0]   issue_kind;
	logic [darr_pkg::TAG_W-1:0]    issue_tag;
	logic                          overflow;

	modport source (output valid, issue_valid, issue_stream, issue_size, issue_kind,
		issue_tag, overflow, input ready);
	modport sink (input valid, issue_valid, issue_stream, issue_size, issue_kind,
		issue_tag, overflow, output ready);
endinterface

[rtl/core/darr_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module darr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/darr_qbook.sv]
// head pointers and fill counts of the per-stream fifos
// depends on darr_pkg (book_op_t); one queue is addressed per cycle
module darr_qbook #(
	parameter int MAX_STREAMS = darr_pkg::MAX_STREAMS_DEF,
	parameter int QUEUE_DEPTH = darr_pkg::QUEUE_DEPTH_DEF,
	localparam int QIW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1,
	localparam int QW  = $clog2(QUEUE_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [QIW-1:0]     idx,
	input  darr_pkg::book_op_t op,
	output logic [QW-1:0]      head,
	output logic [QW-1:0]      tail,
	output logic               full,
	output logic               empty
);
	import darr_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = QW + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	logic [QW-1:0] head_q  [MAX_STREAMS];
	logic [CW-1:0] count_q [MAX_STREAMS];
	logic [QW-1:0] head_cur;
	logic [CW-1:0] cnt_cur;
	logic [SW-1:0] tail_sum;
	logic [SW-1:0] head_sum;
	logic [QW-1:0] head_nxt;

	assign head_cur = head_q[idx];
	assign cnt_cur  = count_q[idx];
	assign tail_sum = SW'(head_cur) + SW'(cnt_cur);
	assign head_sum = SW'(head_cur) + SW'(1);
	assign tail     = (tail_sum >= DEPTH_S) ? QW'(tail_sum - DEPTH_S) : QW'(tail_sum);
	assign head_nxt = (head_sum >= DEPTH_S) ? QW'(head_sum - DEPTH_S) : QW'(head_sum);
	assign head     = head_cur;
	assign full     = (cnt_cur == DEPTH_C);
	assign empty    = (cnt_cur == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_STREAMS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (op.push) begin
				count_q[idx] <= cnt_cur + CW'(1);
			end else if (op.pop) begin
				count_q[idx] <= cnt_cur - CW'(1);
				head_q[idx]  <= head_nxt;
			end
		end
	end

endmodule

[rtl/core/darr_turn_mod.sv]
// shared compare-subtract unit that reduces the round-robin turn modulo the stream count
// no dependencies; one subtraction per cycle until the value is below the modulus
module darr_turn_mod #(
	parameter int W = 4
) (
	input  logic         clk,
	input  logic         load,
	input  logic [W-1:0] load_val,
	input  logic [W-1:0] modulus,
	output logic [W-1:0] result,
	output logic         done
);

	logic [W-1:0] r_q;

	assign done   = (r_q < modulus);
	assign result = r_q;

	always_ff @(posedge clk) begin
		if (load) begin
			r_q <= load_val;
		end else if (!done) begin
			r_q <= r_q - modulus;
		end
	end

endmodule

[rtl/core/dram_access_round_robin_arbiter.sv]
// top level of the dram access round-robin arbiter: sequencer, config port, output register
// depends on darr_pkg, darr_if, darr_ram, darr_qbook and darr_turn_mod
//
// usage
//  req: one beat is a new access request or a completion of the current access.
//  iss: exactly one beat per request beat; it names the access started on the channel,
//   if any, and flags a request dropped because its fifo was full or it has no fifo.
//  apb port: register 0 (byte 0) is shared_queue_mode, register 1 (byte 4) is
//   active_streams; write them only while no beat is in flight.
// sequence of states from the accepting edge to iss.valid
//  new request on an idle channel, or from a stream with no fifo: done.
//  new request queued or dropped on a full fifo: push, done. completion in shared mode:
//   test, read if the fifo is not empty, done. completion in per-stream mode: step,
//   reduce and test per stream visited, staying in reduce while the compare-subtract
//   unit subtracts after a wrap of the turn, then read and done when a fifo head is
//   popped or done when none is. req is taken one beat at a time; ready returns
//   as the result enters the output register.
// reset: channel idle, turn 0, all fifos empty; fifo storage keeps no reset.
// stall: a result waiting on iss does not block the next accept; the sequencer only
//  waits in its last state until the output register frees.
module dram_access_round_robin_arbiter #(
	parameter int MAX_STREAMS = darr_pkg::MAX_STREAMS_DEF,
	parameter int QUEUE_DEPTH = darr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	darr_req_if.sink                    req,
	darr_iss_if.source                  iss,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [darr_pkg::CFG_AW-1:0] paddr,
	input  logic [darr_pkg::CFG_DW-1:0] pwdata,
	output logic [darr_pkg::CFG_DW-1:0] prdata,
	output logic                        pready
);
	import darr_pkg::*;

	localparam int QIW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int QW  = $clog2(QUEUE_DEPTH);
	localparam int TW  = (MAX_STREAMS > 8) ? $clog2(MAX_STREAMS) : STREAM_W;
	localparam int NW  = $clog2(MAX_STREAMS + 1);
	localparam int RW  = TW + 1;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_PUSH   = 7'b0000010,
		S_STEP   = 7'b0000100,
		S_REDUCE = 7'b0001000,
		S_TEST   = 7'b0010000,
		S_READ   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t            state_q;
	logic              mode_q;
	logic [ACT_W-1:0]  streams_q;
	logic              busy_q;
	logic [TW-1:0]     turn_q;
	logic [QIW-1:0]    idx_q;
	logic [NW-1:0]     steps_q;
	entry_t            item_q;
	logic              res_valid_q;
	entry_t            res_entry_q;
	logic              res_ovf_q;
	logic              out_valid_q;
	logic              out_issue_q;
	entry_t            out_entry_q;
	logic              out_ovf_q;

	entry_t            in_entry;
	logic              in_fire;
	logic [TW-1:0]     q_sel;
	logic [NW-1:0]     n_act;
	logic              cfg_wr;
	book_op_t          book_op;
	logic [QW-1:0]     book_head;
	logic [QW-1:0]     book_tail;
	logic              book_full;
	logic              book_empty;
	logic              ram_we;
	logic              ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	logic              mod_load;
	logic [RW-1:0]     mod_result;
	logic              mod_done;
	logic              out_free;

	assign in_entry = '{stream: req.req_stream, size: req.size_bytes,
		kind: req.access_kind, tag: req.request_tag};
	assign req.ready = (state_q == S_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign q_sel     = mode_q ? '0 : TW'(req.req_stream);
	assign out_free  = !out_valid_q || iss.ready;

	// active stream count clamped to one..MAX_STREAMS
	always_comb begin
		if (streams_q == '0) begin
			n_act = NW'(1);
		end else if (int'(streams_q) > MAX_STREAMS) begin
			n_act = NW'(MAX_STREAMS);
		end else begin
			n_act = NW'(streams_q);
		end
	end

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_MODE:    prdata = CFG_DW'(mode_q);
			REG_STREAMS: prdata = CFG_DW'(streams_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			streams_q <= ACT_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_MODE:    mode_q    <= pwdata[0];
				REG_STREAMS: streams_q <= pwdata[ACT_W-1:0];
				default:     ;
			endcase
		end
	end

	// fifo bookkeeping and storage
	assign book_op.push = (state_q == S_PUSH) && !book_full;
	assign book_op.pop  = (state_q == S_TEST) && !book_empty;
	assign ram_we       = book_op.push;
	assign ram_re       = book_op.pop;

	darr_qbook #(
		.MAX_STREAMS(MAX_STREAMS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_qbook (
		.clk   (clk),
		.arst_n(arst_n),
		.idx   (idx_q),
		.op    (book_op),
		.head  (book_head),
		.tail  (book_tail),
		.full  (book_full),
		.empty (book_empty)
	);

	darr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(2 ** (QIW + QW))
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr({idx_q, book_tail}),
		.wdata(item_q),
		.re   (ram_re),
		.raddr({idx_q, book_head}),
		.rdata(ram_rdata)
	);

	// turn advance
	assign mod_load = (state_q == S_STEP);

	darr_turn_mod #(
		.W(RW)
	) u_turn_mod (
		.clk     (clk),
		.load    (mod_load),
		.load_val(RW'(turn_q) + RW'(1)),
		.modulus (RW'(n_act)),
		.result  (mod_result),
		.done    (mod_done)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			turn_q  <= '0;
			idx_q   <= '0;
			steps_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (req.req_type == REQ_NEW) begin
							if (!busy_q) begin
								busy_q  <= 1'b1;
								turn_q  <= TW'(req.req_stream);
								state_q <= S_DONE;
							end else if (int'(q_sel) >= MAX_STREAMS) begin
								state_q <= S_DONE;
							end else begin
								idx_q   <= QIW'(q_sel);
								state_q <= S_PUSH;
							end
						end else begin
							busy_q  <= 1'b0;
							steps_q <= '0;
							if (mode_q) begin
								idx_q   <= '0;
								state_q <= S_TEST;
							end else begin
								state_q <= S_STEP;
							end
						end
					end
				end
				S_PUSH: begin
					state_q <= S_DONE;
				end
				S_STEP: begin
					state_q <= S_REDUCE;
				end
				S_REDUCE: begin
					if (mod_done) begin
						turn_q  <= TW'(mod_result);
						idx_q   <= QIW'(mod_result);
						state_q <= S_TEST;
					end
				end
				S_TEST: begin
					if (!book_empty) begin
						state_q <= S_READ;
					end else if (mode_q || (steps_q + NW'(1) == n_act)) begin
						state_q <= S_DONE;
					end else begin
						steps_q <= steps_q + NW'(1);
						state_q <= S_STEP;
					end
				end
				S_READ: begin
					busy_q  <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result staging
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q      <= in_entry;
			res_valid_q <= 1'b0;
			res_entry_q <= '0;
			res_ovf_q   <= 1'b0;
			if (req.req_type == REQ_NEW) begin
				if (!busy_q) begin
					res_valid_q <= 1'b1;
					res_entry_q <= in_entry;
				end else if (int'(q_sel) >= MAX_STREAMS) begin
					res_ovf_q <= 1'b1;
				end
			end
		end else if (state_q == S_PUSH) begin
			res_ovf_q <= book_full;
		end else if (state_q == S_READ) begin
			res_valid_q <= 1'b1;
			res_entry_q <= entry_t'(ram_rdata);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (iss.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_issue_q <= res_valid_q;
			out_entry_q <= res_entry_q;
			out_ovf_q   <= res_ovf_q;
		end
	end

	assign iss.valid        = out_valid_q;
	assign iss.issue_valid  = out_issue_q;
	assign iss.issue_stream = out_entry_q.stream;
	assign iss.issue_size   = out_entry_q.size;
	assign iss.issue_kind   = out_entry_q.kind;
	assign iss.issue_tag    = out_entry_q.tag;
	assign iss.overflow     = out_ovf_q;

endmodule

[rtl/core/darr_chk.sv]
// port-level checker of the dram access round-robin arbiter and its bind
// depends on darr_pkg for field widths; watches only the top level's ports
module darr_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          issue_valid,
	input logic [darr_pkg::STREAM_W-1:0] issue_stream,
	input logic [darr_pkg::SIZE_W-1:0]   issue_size,
	input logic [darr_pkg::KIND_W-1:0]   issue_kind,
	input logic [darr_pkg::TAG_W-1:0]    issue_tag,
	input logic                          overflow
);

	// a dropped request never starts an access
	a_ovf_no_issue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> !issue_valid)
		else $error("overflow beat also issues an access");

	// fields of a beat without an access are zero
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !issue_valid |->
			issue_stream == '0 && issue_size == '0 && issue_kind == '0 && issue_tag == '0)
		else $error("issue fields not zero without an access");

	// one request beat at a time: ready drops after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken before the first finished");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(issue_valid) && $stable(issue_tag)
			&& $stable(overflow))
		else $error("result beat changed while stalled");

endmodule

bind dram_access_round_robin_arbiter darr_chk u_darr_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (iss.valid),
	.out_ready   (iss.ready),
	.issue_valid (iss.issue_valid),
	.issue_stream(iss.issue_stream),
	.issue_size  (iss.issue_size),
	.issue_kind  (iss.issue_kind),
	.issue_tag   (iss.issue_tag),
	.overflow    (iss.overflow)
);

[tb/sv/tb_dram_access_round_robin_arbiter.sv]
// self-checking testbench of the dram access round-robin arbiter: directed and random
// request beats checked against an arbitration predictor kept in the testbench
// depends on darr_pkg, darr_if and the rtl top dram_access_round_robin_arbiter
module tb_dram_access_round_robin_arbiter;
	timeunit 1ns;
	timeprecision 1ps;
	import darr_pkg::*;

	localparam int NSTR          = MAX_STREAMS_DEF;
	localparam int QDEPTH        = QUEUE_DEPTH_DEF;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 60;
	localparam int PHASE_ITEMS   = 170;

	typedef enum int {
		IDLE_NONE,
		IDLE_TX,
		IDLE_RX,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic                issue_valid;
		logic [STREAM_W-1:0] stream;
		logic [SIZE_W-1:0]   size;
		logic [KIND_W-1:0]   kind;
		logic [TAG_W-1:0]    tag;
		logic                overflow;
	} issue_beat_t;

	typedef struct packed {
		req_type_t rtype;
		entry_t    body;
	} access_req_t;

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite, pready;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata, prdata;

	darr_req_if req ();
	darr_iss_if iss ();

	dram_access_round_robin_arbiter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.iss     (iss),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// arbitration state as the block should hold it
	logic                mode_cfg;
	logic [ACT_W-1:0]    streams_cfg;
	logic                busy_pred;
	logic [STREAM_W-1:0] turn_pred;
	entry_t              fifo_pred [NSTR][$];

	access_req_t access_pend_q [$];
	issue_beat_t issue_expect_q [$];
	int          fail_count   = 0;
	int          tx_idle_pct  = 0;
	int          rx_stall_pct = 0;
	logic        rx_hold      = 1'b0;
	logic        hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("tb_dram_access_round_robin_arbiter: FAIL");
		$finish;
	end

	function automatic issue_beat_t predict_issue(access_req_t a);
		issue_beat_t r;
		int          q;
		int          n;
		r = '0;
		if (a.rtype == REQ_NEW) begin
			if (!busy_pred) begin
				busy_pred = 1'b1;
				turn_pred = a.body.stream;
				r = {1'b1, a.body, 1'b0};
			end else begin
				q = mode_cfg ? 0 : int'(a.body.stream);
				if (fifo_pred[q].size() >= QDEPTH)
					r.overflow = 1'b1;
				else
					fifo_pred[q] = {fifo_pred[q], a.body};
			end
		end else begin
			busy_pred = 1'b0;
			if (mode_cfg) begin
				if (fifo_pred[0].size() > 0) begin
					busy_pred = 1'b1;
					r = {1'b1, fifo_pred[0].pop_front(), 1'b0};
				end
			end else begin
				n = (streams_cfg == 0) ? 1 : ((streams_cfg > NSTR) ? NSTR : int'(streams_cfg));
				for (int i = 0; i < n && !busy_pred; i++) begin
					turn_pred = STREAM_W'((int'(turn_pred) + 1) % n);
					if (fifo_pred[turn_pred].size() > 0) begin
						busy_pred = 1'b1;
						r = {1'b1, fifo_pred[turn_pred].pop_front(), 1'b0};
					end
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("%0t mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic check_issue_beat(issue_beat_t got);
		issue_beat_t want;
		if (issue_expect_q.size() == 0) begin
			report_mismatch("beat with nothing expected, tag", got.tag, 0);
		end else begin
			want = issue_expect_q.pop_front();
			if (got.issue_valid !== want.issue_valid)
				report_mismatch("issue_valid", got.issue_valid, want.issue_valid);
			if (got.stream !== want.stream)
				report_mismatch("issue_stream", got.stream, want.stream);
			if (got.size !== want.size)
				report_mismatch("issue_size", got.size, want.size);
			if (got.kind !== want.kind)
				report_mismatch("issue_kind", got.kind, want.kind);
			if (got.tag !== want.tag)
				report_mismatch("issue_tag", got.tag, want.tag);
			if (got.overflow !== want.overflow)
				report_mismatch("overflow", got.overflow, want.overflow);
		end
	endtask

	// request driver: holds a beat until taken, prediction at acceptance
	always @(posedge clk or negedge arst_n) begin
		access_req_t beat;
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				beat.rtype = req_type_t'(req.req_type);
				beat.body  = {req.req_stream, req.size_bytes, req.access_kind, req.request_tag};
				issue_expect_q = {issue_expect_q, predict_issue(beat)};
			end
			if (!(req.valid && !req.ready)) begin
				if (access_pend_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					beat = access_pend_q.pop_front();
					req.valid       <= 1'b1;
					req.req_type    <= beat.rtype;
					req.req_stream  <= beat.body.stream;
					req.size_bytes  <= beat.body.size;
					req.access_kind <= beat.body.kind;
					req.request_tag <= beat.body.tag;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// issue monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss.ready <= 1'b0;
		end else begin
			if (iss.valid && iss.ready)
				check_issue_beat({iss.issue_valid, iss.issue_stream, iss.issue_size,
					iss.issue_kind, iss.issue_tag, iss.overflow});
			iss.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// long receiver hold-off so the block backs up into the request side
	initial begin
		wait (hold_request);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] value);
		logic [CFG_DW-1:0] mask;
		mask = (idx == REG_MODE) ? CFG_DW'(1) : CFG_DW'((1 << ACT_W) - 1);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_MODE)
			mode_cfg = value[0];
		else
			streams_cfg = value[ACT_W-1:0];
		// read back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (value & mask))
			report_mismatch("register readback", prdata & mask, value & mask);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_drained();
		while (access_pend_q.size() > 0 || req.valid || issue_expect_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic queue_access(req_type_t t, int s, int sz, int k, int tg);
		access_req_t a;
		a.rtype = t;
		a.body  = {STREAM_W'(s), SIZE_W'(sz), KIND_W'(k), TAG_W'(tg)};
		access_pend_q = {access_pend_q, a};
	endtask

	function automatic access_req_t random_access(int new_pct, logic [STREAM_W-1:0] hot);
		access_req_t a;
		a.rtype = ($urandom_range(99) < new_pct) ? REQ_NEW : REQ_DONE;
		a.body.stream = ($urandom_range(1) == 1) ? hot : STREAM_W'($urandom_range(NSTR - 1));
		case ($urandom_range(7))
			0: a.body.size = '0;
			1: a.body.size = '1;
			default: a.body.size = SIZE_W'($urandom);
		endcase
		a.body.kind = KIND_W'($urandom);
		a.body.tag  = TAG_W'($urandom);
		return a;
	endfunction

	task automatic run_phase(logic mode, logic [ACT_W-1:0] nstreams, idle_mode_t idling,
		int count, logic with_hold);
		int                  new_pct;
		logic [STREAM_W-1:0] hot;
		write_reg(REG_MODE, CFG_DW'(mode));
		write_reg(REG_STREAMS, CFG_DW'(nstreams));
		case (idling)
			IDLE_NONE: begin
				tx_idle_pct  = 0;
				rx_stall_pct = 0;
			end
			IDLE_TX: begin
				tx_idle_pct  = 82;
				rx_stall_pct = 0;
			end
			IDLE_RX: begin
				tx_idle_pct  = 0;
				rx_stall_pct = 82;
			end
			default: begin
				tx_idle_pct  = 8;
				rx_stall_pct = 8;
			end
		endcase
		new_pct = $urandom_range(80, 50);
		hot     = STREAM_W'($urandom_range(NSTR - 1));
		if (with_hold)
			hold_request = 1'b1;
		for (int i = 0; i < count; i++) begin
			// sender pause until every issue beat is back
			if (i == count / 2)
				wait_drained();
			access_pend_q = {access_pend_q, random_access(new_pct, hot)};
		end
		wait_drained();
	endtask

	initial begin
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.req_type    = 1'b0;
		req.req_stream  = '0;
		req.size_bytes  = '0;
		req.access_kind = '0;
		req.request_tag = '0;
		iss.ready       = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		mode_cfg        = 1'b0;
		streams_cfg     = ACT_W'(1);
		busy_pred       = 1'b0;
		turn_pred       = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_reg(REG_MODE, 0);
		write_reg(REG_STREAMS, 4);
		// turn outside the active range, stream outside the active range
		queue_access(REQ_NEW, 6, 20'hFFFFF, 3, 16'hFFFF);
		queue_access(REQ_NEW, 1, 0, 0, 0);
		queue_access(REQ_NEW, 5, 20'h5A5A5, 2, 16'h1234);
		queue_access(REQ_DONE, 7, 20'hFFFFF, 3, 16'hFFFF);
		queue_access(REQ_DONE, 0, 0, 0, 0);
		// completion on an idle channel
		queue_access(REQ_DONE, 2, 20'h12345, 1, 16'h8001);
		queue_access(REQ_NEW, 3, 20'hABCDE, 1, 16'h00FF);
		// fill one fifo past its depth
		for (int i = 0; i < QDEPTH + 1; i++)
			queue_access(REQ_NEW, 3, $urandom, $urandom, $urandom);
		queue_access(REQ_DONE, 3, 0, 0, 0);
		wait_drained();

		run_phase(1'b1, 8, IDLE_NONE, PHASE_ITEMS, 1'b0);
		run_phase(1'b0, 8, IDLE_TX, PHASE_ITEMS, 1'b0);
		run_phase(1'b0, 0, IDLE_RX, PHASE_ITEMS, 1'b0);
		run_phase(1'b0, 15, IDLE_BOTH, PHASE_ITEMS, 1'b0);
		run_phase(1'b1, 3, IDLE_NONE, PHASE_ITEMS, 1'b1);
		run_phase(1'b0, 1, IDLE_TX, PHASE_ITEMS, 1'b0);
		run_phase(1'b0, 5, IDLE_RX, PHASE_ITEMS, 1'b0);
		run_phase(1'b1, 15, IDLE_BOTH, PHASE_ITEMS, 1'b0);
		run_phase(1'b0, 8, IDLE_NONE, PHASE_ITEMS, 1'b0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && issue_expect_q.size() == 0)
			$display("tb_dram_access_round_robin_arbiter: PASS");
		else
			$display("tb_dram_access_round_robin_arbiter: FAIL");
		$finish;
	end

endmodule
